### src/spq_pkg.sv
// shared types, constants and status codes of the sorted priority queue
package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int COST_W    = 32;
	localparam int TAG_W     = 8;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic              operation;
		logic [COST_W-1:0] cost;
		logic [TAG_W-1:0]  period;
		logic [TAG_W-1:0]  plant;
	} item_t;

	typedef struct packed {
		logic [COST_W-1:0]   head_cost;
		logic [TAG_W-1:0]    head_period;
		logic [TAG_W-1:0]    head_plant;
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occupancy;
	} result_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [TAG_W-1:0]  period;
		logic [TAG_W-1:0]  plant;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t fresh;
	} cell_ctrl_t;

endpackage

### src/spq_cell.sv
// one slot of the sorted chain: compares against the new key and shifts with its neighbors
module spq_cell #(
	parameter int CNT_W = 5,
	parameter int INDEX = 0
) (
	input  logic                  clk,
	input  spq_pkg::cell_ctrl_t   ctrl,
	input  logic [CNT_W-1:0]      count,
	input  logic                  left_gt,
	input  spq_pkg::entry_t       left_entry,
	input  spq_pkg::entry_t       right_entry,
	output logic                  gt,
	output spq_pkg::entry_t       entry
);

	spq_pkg::entry_t entry_q;
	logic            occupied;

	assign occupied = CNT_W'(INDEX) < count;
	assign gt       = occupied && (entry_q.cost > ctrl.fresh.cost);
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			priority if (gt) begin
				entry_q <= entry_q;
			end else if (left_gt) begin
				entry_q <= ctrl.fresh;
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

### src/sorted_priority_queue_core.sv
// top level of the sorted priority queue: cell chain, entry count and result register
//
// Takes one insert or pop beat in every cycle (busy stays low) and answers each beat with
// exactly one result, shown for a single cycle with done high, in the cycle after the beat.
// The receiver cannot stall, so the result must be captured in that cycle. Every slot of
// the chain compares its key with the new key in parallel and shifts with its neighbors,
// so the rate is set by one compare and one select per cell, independent of DEPTH.
// Entries are kept in descending order of cost; equal costs put the newest first.
// Occupancy shows the low five bits of the entry count.
module sorted_priority_queue_core #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  spq_pkg::item_t   item,
	output logic             done,
	output spq_pkg::result_t result
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]    count_q;
	logic                done_q;
	spq_pkg::result_t    result_q;
	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::entry_t     entries [DEPTH];
	logic                gts     [DEPTH];
	logic                accept;
	logic                full;
	logic                empty;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;

	assign ctrl.ins   = accept && (item.operation == spq_pkg::OP_INSERT) && !full;
	assign ctrl.pop   = accept && (item.operation == spq_pkg::OP_POP) && !empty;
	assign ctrl.fresh = '{cost: item.cost, period: item.period, plant: item.plant};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::entry_t l_entry;
		spq_pkg::entry_t r_entry;
		logic            l_gt;

		if (i == 0) begin : g_first
			assign l_entry = ctrl.fresh;
			assign l_gt    = 1'b1;
		end else begin : g_mid
			assign l_entry = entries[i-1];
			assign l_gt    = gts[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_entry = '0;
		end else begin : g_inner
			assign r_entry = entries[i+1];
		end

		spq_cell #(
			.CNT_W(CNT_W),
			.INDEX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.left_gt    (l_gt),
			.left_entry (l_entry),
			.right_entry(r_entry),
			.gt         (gts[i]),
			.entry      (entries[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctrl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			priority if (ctrl.ins) begin
				result_q.head_cost   <= '0;
				result_q.head_period <= '0;
				result_q.head_plant  <= '0;
				result_q.status      <= spq_pkg::ST_OK;
				result_q.occupancy   <= spq_pkg::OCC_W'(count_q + CNT_W'(1));
			end else if (ctrl.pop) begin
				result_q.head_cost   <= entries[0].cost;
				result_q.head_period <= entries[0].period;
				result_q.head_plant  <= entries[0].plant;
				result_q.status      <= spq_pkg::ST_OK;
				result_q.occupancy   <= spq_pkg::OCC_W'(count_q - CNT_W'(1));
			end else if (item.operation == spq_pkg::OP_INSERT) begin
				result_q.head_cost   <= '0;
				result_q.head_period <= '0;
				result_q.head_plant  <= '0;
				result_q.status      <= spq_pkg::ST_FULL;
				result_q.occupancy   <= spq_pkg::OCC_W'(count_q);
			end else begin
				result_q.head_cost   <= '0;
				result_q.head_period <= '0;
				result_q.head_plant  <= '0;
				result_q.status      <= spq_pkg::ST_EMPTY;
				result_q.occupancy   <= '0;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
